// ----- rtl/core/pfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared widths, register indexes and types of the posit field decoder.
// ----------------------------------------------------------------------------
package pfd_pkg;

   // Field widths of the request and response items
   localparam int WORD_BITS = 64;
   localparam int WW_BITS   = 7;
   localparam int ES_BITS   = 5;
   localparam int RS_BITS   = 6;
   localparam int K_BITS    = 7;
   localparam int EV_BITS   = 16;
   localparam int FS_BITS   = 6;
   localparam int FB_BITS   = 61;

   // Configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic CSR_WORD_WIDTH = 1'b0;
   localparam logic CSR_EXP_WIDTH  = 1'b1;

   localparam logic [WW_BITS-1:0] WW_RESET = 7'd32;
   localparam logic [ES_BITS-1:0] ES_RESET = 5'd8;
   localparam logic [ES_BITS-1:0] ES_LIMIT = 5'd16;

   // Word classification that travels down the pipe
   typedef struct packed {
      logic neg;
      logic zero;
      logic nar;
      logic rsign;
   } pfd_flags_type;

endpackage : pfd_pkg
`default_nettype wire

// ----- rtl/core/pfd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_req_if / pfd_rsp_if
// Valid/ready channels of the posit field decoder.
// ----------------------------------------------------------------------------
interface pfd_req_if;
   logic                          valid;
   logic                          ready;
   logic [pfd_pkg::WORD_BITS-1:0] posit_word;

   modport source (output valid, output posit_word, input ready);
   modport sink   (input valid, input posit_word, output ready);
endinterface : pfd_req_if

interface pfd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              sign;
   logic                              is_zero;
   logic                              is_nar;
   logic [pfd_pkg::RS_BITS-1:0]       regime_size;
   logic signed [pfd_pkg::K_BITS-1:0] regime_value;
   logic [pfd_pkg::ES_BITS-1:0]       exponent_size;
   logic [pfd_pkg::EV_BITS-1:0]       exponent_value;
   logic [pfd_pkg::FS_BITS-1:0]       fraction_size;
   logic [pfd_pkg::FB_BITS-1:0]       fraction_bits;

   modport source (output valid, output sign, output is_zero, output is_nar,
                   output regime_size, output regime_value, output exponent_size,
                   output exponent_value, output fraction_size, output fraction_bits,
                   input ready);
   modport sink   (input valid, input sign, input is_zero, input is_nar,
                   input regime_size, input regime_value, input exponent_size,
                   input exponent_value, input fraction_size, input fraction_bits,
                   output ready);
endinterface : pfd_rsp_if
`default_nettype wire

// ----- rtl/core/pfd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_front
// Stages 1-2: mask and sign-correct the word, then left-align the regime
// with a stop bit so that a plain leading-zero count measures the run.
// ----------------------------------------------------------------------------
module pfd_front #(
   parameter int DW = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [pfd_pkg::WW_BITS-1:0]   n,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [DW-1:0]                 in_word,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [DW-1:0]                      out_sb,
   output logic [DW-1:0]                      out_run,
   output pfd_pkg::pfd_flags_type             out_flags
);
   import pfd_pkg::*;

   localparam logic [WW_BITS-1:0] DW_W   = WW_BITS'(DW);
   localparam logic [WW_BITS-1:0] DW_W1  = WW_BITS'(DW + 1);
   localparam logic [DW-1:0]      ONES   = {DW{1'b1}};
   localparam logic [DW-1:0]      ONE    = {{(DW-1){1'b0}}, 1'b1};

   logic                 s1_v_ff, s2_v_ff;
   logic                 s1_rdy, s2_rdy;
   logic [DW-1:0]        s1_sb_ff, s1_sb_in;
   pfd_flags_type        s1_fl_ff, s1_fl_in;
   logic [DW-1:0]        s2_sb_ff;
   logic [DW-1:0]        s2_run_ff, s2_run_in;
   pfd_flags_type        s2_fl_ff, s2_fl_in;

   logic [DW-1:0]        mask, top, word;
   logic [WW_BITS-1:0]   sh;
   logic [DW-1:0]        aligned;

   // Handshake: a stage moves when it is empty or its successor moves
   assign s2_rdy    = !s2_v_ff || out_ready;
   assign s1_rdy    = !s1_v_ff || s2_rdy;
   assign in_ready  = s1_rdy;
   assign out_valid = s2_v_ff;
   assign out_sb    = s2_sb_ff;
   assign out_run   = s2_run_ff;
   assign out_flags = s2_fl_ff;

   // Stage 1: mask to n bits, classify, two's-complement negative words
   always_comb begin
      mask  = ONES >> (DW_W - n);
      top   = ONE << (n - 7'd1);
      word  = in_word & mask;
      s1_fl_in.neg   = |(word & top);
      s1_fl_in.zero  = (word == '0);
      s1_fl_in.nar   = (word == top);
      s1_fl_in.rsign = 1'b0;
      if (s1_fl_in.neg) begin
         s1_sb_in = ((~word + ONE) & mask) | top;
      end else begin
         s1_sb_in = word;
      end
   end

   // Stage 2: move bit n-2 to the top, fold the run to zeros, plant stop bit
   always_comb begin
      sh             = DW_W1 - n;
      aligned        = s1_sb_ff << sh;
      s2_fl_in       = s1_fl_ff;
      s2_fl_in.rsign = aligned[DW-1];
      s2_run_in      = (aligned[DW-1] ? ~aligned : aligned) | (ONE << sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_v_ff <= in_valid;
         end
         if (s2_rdy) begin
            s2_v_ff <= s1_v_ff;
         end
      end
      if (s1_rdy) begin
         s1_sb_ff <= s1_sb_in;
         s1_fl_ff <= s1_fl_in;
      end
      if (s2_rdy) begin
         s2_sb_ff  <= s1_sb_ff;
         s2_run_ff <= s2_run_in;
         s2_fl_ff  <= s2_fl_in;
      end
   end

endmodule : pfd_front
`default_nettype wire

// ----- rtl/core/pfd_regime.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_regime
// Stages 3-4: count the regime run, then size the exponent and fraction
// fields and form the regime value k.
// ----------------------------------------------------------------------------
module pfd_regime #(
   parameter int DW = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [pfd_pkg::WW_BITS-1:0]   n,
   input  wire logic [pfd_pkg::ES_BITS-1:0]   esm,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [DW-1:0]                 in_sb,
   input  wire logic [DW-1:0]                 in_run,
   input  wire pfd_pkg::pfd_flags_type        in_flags,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [DW-1:0]                      out_sb,
   output pfd_pkg::pfd_flags_type             out_flags,
   output logic [pfd_pkg::RS_BITS-1:0]        out_rs,
   output logic [pfd_pkg::K_BITS-1:0]         out_k,
   output logic [pfd_pkg::ES_BITS-1:0]        out_es,
   output logic [pfd_pkg::FS_BITS-1:0]        out_fs
);
   import pfd_pkg::*;

   localparam int LW = $clog2(DW);

   logic                 s3_v_ff, s4_v_ff;
   logic                 s3_rdy, s4_rdy;
   logic [DW-1:0]        s3_sb_ff, s4_sb_ff;
   pfd_flags_type        s3_fl_ff, s4_fl_ff;
   logic [RS_BITS-1:0]   s3_rs_ff, s3_rs_in;
   logic [RS_BITS-1:0]   s4_rs_ff;
   logic [K_BITS-1:0]    s4_k_ff, s4_k_in;
   logic [ES_BITS-1:0]   s4_es_ff, s4_es_in;
   logic [FS_BITS-1:0]   s4_fs_ff, s4_fs_in;

   logic [LW-1:0]        lz;
   logic [WW_BITS-1:0]   rs_w, avail, fs_w;

   assign s4_rdy    = !s4_v_ff || out_ready;
   assign s3_rdy    = !s3_v_ff || s4_rdy;
   assign in_ready  = s3_rdy;
   assign out_valid = s4_v_ff;
   assign out_sb    = s4_sb_ff;
   assign out_flags = s4_fl_ff;
   assign out_rs    = s4_rs_ff;
   assign out_k     = s4_k_ff;
   assign out_es    = s4_es_ff;
   assign out_fs    = s4_fs_ff;

   // Stage 3: leading-zero count; the stop bit bounds it at n-2
   always_comb begin
      lz = '0;
      for (int i = 0; i < DW; i++) begin
         if (in_run[i]) begin
            lz = LW'(DW - 1 - i);
         end
      end
      s3_rs_in = RS_BITS'(lz) + 6'd1;
   end

   // Stage 4: field sizes and regime value
   always_comb begin
      rs_w  = {1'b0, s3_rs_ff};
      avail = n - 7'd1 - rs_w;
      if (avail > {2'b00, esm}) begin
         s4_es_in = esm;
      end else begin
         s4_es_in = avail[ES_BITS-1:0];
      end
      fs_w     = avail - {2'b00, s4_es_in};
      s4_fs_in = fs_w[FS_BITS-1:0];
      if (s3_fl_ff.zero || s3_fl_ff.nar) begin
         s4_k_in = 7'd0 - rs_w;
      end else if (s3_fl_ff.rsign) begin
         // run fills every bit below the sign: k is the run length minus one
         if (rs_w == n - 7'd1 && s3_sb_ff[0]) begin
            s4_k_in = rs_w - 7'd1;
         end else begin
            s4_k_in = rs_w - 7'd2;
         end
      end else begin
         s4_k_in = 7'd1 - rs_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s3_rdy) begin
            s3_v_ff <= in_valid;
         end
         if (s4_rdy) begin
            s4_v_ff <= s3_v_ff;
         end
      end
      if (s3_rdy) begin
         s3_sb_ff <= in_sb;
         s3_fl_ff <= in_flags;
         s3_rs_ff <= s3_rs_in;
      end
      if (s4_rdy) begin
         s4_sb_ff <= s3_sb_ff;
         s4_fl_ff <= s3_fl_ff;
         s4_rs_ff <= s3_rs_ff;
         s4_k_ff  <= s4_k_in;
         s4_es_ff <= s4_es_in;
         s4_fs_ff <= s4_fs_in;
      end
   end

endmodule : pfd_regime
`default_nettype wire

// ----- rtl/core/pfd_extract.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_extract
// Stages 5-6: split off the fraction, then cut and left-align the exponent.
// Stage 6 is the output register of the block.
// ----------------------------------------------------------------------------
module pfd_extract #(
   parameter int DW = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [pfd_pkg::ES_BITS-1:0]   esm,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [DW-1:0]                 in_sb,
   input  wire pfd_pkg::pfd_flags_type        in_flags,
   input  wire logic [pfd_pkg::RS_BITS-1:0]   in_rs,
   input  wire logic [pfd_pkg::K_BITS-1:0]    in_k,
   input  wire logic [pfd_pkg::ES_BITS-1:0]   in_es,
   input  wire logic [pfd_pkg::FS_BITS-1:0]   in_fs,
   pfd_rsp_if.source                          rsp
);
   import pfd_pkg::*;

   localparam logic [DW-1:0] ONES = {DW{1'b1}};

   logic                 s5_v_ff, s6_v_ff;
   logic                 s5_rdy, s6_rdy;
   pfd_flags_type        s5_fl_ff, s6_fl_ff;
   logic [RS_BITS-1:0]   s5_rs_ff, s6_rs_ff;
   logic [K_BITS-1:0]    s5_k_ff, s6_k_ff;
   logic [ES_BITS-1:0]   s5_es_ff, s6_es_ff;
   logic [FS_BITS-1:0]   s5_fs_ff, s6_fs_ff;
   logic [DW-1:0]        s5_fb_ff, s5_fb_in;
   logic [DW-1:0]        s5_hi_ff, s5_hi_in;
   logic [FB_BITS-1:0]   s6_fb_ff;
   logic [EV_BITS-1:0]   s6_ev_ff, s6_ev_in;

   logic [WORD_BITS-1:0] fb_wide, hi_wide;
   logic [EV_BITS:0]     ev_mask;

   assign s6_rdy   = !s6_v_ff || rsp.ready;
   assign s5_rdy   = !s5_v_ff || s6_rdy;
   assign in_ready = s5_rdy;

   // Stage 5: fraction is the low fs bits; drop them from the rest
   always_comb begin
      s5_fb_in = in_sb & ~(ONES << in_fs);
      s5_hi_in = in_sb >> in_fs;
   end

   // Stage 6: keep es exponent bits, pad truncated ones with zeros
   always_comb begin
      fb_wide  = WORD_BITS'(s5_fb_ff);
      hi_wide  = WORD_BITS'(s5_hi_ff);
      ev_mask  = (17'd1 << s5_es_ff) - 17'd1;
      s6_ev_in = (hi_wide[EV_BITS-1:0] & ev_mask[EV_BITS-1:0]) << (esm - s5_es_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else begin
         if (s5_rdy) begin
            s5_v_ff <= in_valid;
         end
         if (s6_rdy) begin
            s6_v_ff <= s5_v_ff;
         end
      end
      if (s5_rdy) begin
         s5_fl_ff <= in_flags;
         s5_rs_ff <= in_rs;
         s5_k_ff  <= in_k;
         s5_es_ff <= in_es;
         s5_fs_ff <= in_fs;
         s5_fb_ff <= s5_fb_in;
         s5_hi_ff <= s5_hi_in;
      end
      if (s6_rdy) begin
         s6_fl_ff <= s5_fl_ff;
         s6_rs_ff <= s5_rs_ff;
         s6_k_ff  <= s5_k_ff;
         s6_es_ff <= s5_es_ff;
         s6_fs_ff <= s5_fs_ff;
         s6_fb_ff <= fb_wide[FB_BITS-1:0];
         s6_ev_ff <= s6_ev_in;
      end
   end

   // Drive the response channel from the output register
   assign rsp.valid          = s6_v_ff;
   assign rsp.sign           = s6_fl_ff.neg;
   assign rsp.is_zero        = s6_fl_ff.zero;
   assign rsp.is_nar         = s6_fl_ff.nar;
   assign rsp.regime_size    = s6_rs_ff;
   assign rsp.regime_value   = $signed(s6_k_ff);
   assign rsp.exponent_size  = s6_es_ff;
   assign rsp.exponent_value = s6_ev_ff;
   assign rsp.fraction_size  = s6_fs_ff;
   assign rsp.fraction_bits  = s6_fb_ff;

endmodule : pfd_extract
`default_nettype wire

// ----- rtl/core/posit_field_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// posit_field_decoder
// A request passes through six register stages, s1 to s6, on its way to the response.
// Throughput: one request per cycle; a stalled response holds the pipe in place.
// Reset (synchronous, active high) empties the pipe and sets word_width to 32
// and exponent_width to 8.
// Splits a posit word of configurable width into sign, regime, exponent and
// fraction fields.
// ----------------------------------------------------------------------------
module posit_field_decoder #(
   parameter int MAX_WIDTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   pfd_req_if.sink                                  req,
   pfd_rsp_if.source                                rsp,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [pfd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [pfd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [pfd_pkg::CSR_DATA_BITS-1:0]        prdata,
   output logic                                     pready
);
   import pfd_pkg::*;

   localparam logic [WW_BITS-1:0] MAX_W = WW_BITS'(MAX_WIDTH);

   logic [WW_BITS-1:0]   ww_ff;
   logic [ES_BITS-1:0]   es_ff, es_in;
   logic                 wr_en;
   logic                 reg_sel;
   logic [WW_BITS-1:0]   n;

   logic                 f_valid, f_ready;
   logic [MAX_WIDTH-1:0] f_sb, f_run;
   pfd_flags_type        f_flags;

   logic                 r_valid, r_ready;
   logic [MAX_WIDTH-1:0] r_sb;
   pfd_flags_type        r_flags;
   logic [RS_BITS-1:0]   r_rs;
   logic [K_BITS-1:0]    r_k;
   logic [ES_BITS-1:0]   r_es;
   logic [FS_BITS-1:0]   r_fs;

   // Register port
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];
   assign es_in   = (pwdata[ES_BITS-1:0] > ES_LIMIT) ? ES_LIMIT : pwdata[ES_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ww_ff <= WW_RESET;
         es_ff <= ES_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            CSR_WORD_WIDTH: ww_ff <= pwdata[WW_BITS-1:0];
            CSR_EXP_WIDTH:  es_ff <= es_in;
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_WORD_WIDTH: prdata = CSR_DATA_BITS'(ww_ff);
         CSR_EXP_WIDTH:  prdata = CSR_DATA_BITS'(es_ff);
         default:        prdata = '0;
      endcase
   end

   // Clamp the width into the supported range
   always_comb begin
      if (ww_ff < 7'd2) begin
         n = 7'd2;
      end else if (ww_ff > MAX_W) begin
         n = MAX_W;
      end else begin
         n = ww_ff;
      end
   end

   pfd_front #(.DW(MAX_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .n         (n),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_word   (req.posit_word[MAX_WIDTH-1:0]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_sb    (f_sb),
      .out_run   (f_run),
      .out_flags (f_flags)
   );

   pfd_regime #(.DW(MAX_WIDTH)) u_regime (
      .clock     (clock),
      .reset     (reset),
      .n         (n),
      .esm       (es_ff),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_sb     (f_sb),
      .in_run    (f_run),
      .in_flags  (f_flags),
      .out_valid (r_valid),
      .out_ready (r_ready),
      .out_sb    (r_sb),
      .out_flags (r_flags),
      .out_rs    (r_rs),
      .out_k     (r_k),
      .out_es    (r_es),
      .out_fs    (r_fs)
   );

   pfd_extract #(.DW(MAX_WIDTH)) u_extract (
      .clock    (clock),
      .reset    (reset),
      .esm      (es_ff),
      .in_valid (r_valid),
      .in_ready (r_ready),
      .in_sb    (r_sb),
      .in_flags (r_flags),
      .in_rs    (r_rs),
      .in_k     (r_k),
      .in_es    (r_es),
      .in_fs    (r_fs),
      .rsp      (rsp)
   );

endmodule : posit_field_decoder
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posit_field_decoder testbench
// Drives posit words through the decoder under a range of word and exponent
// widths, predicts every field of each response in a local decoder and checks
// them in order. Both channels idle and stall at random; the configuration is
// rewritten over the APB-style port only once the pipe has drained.
// ----------------------------------------------------------------------------
module testbench;
   import pfd_pkg::*;

   localparam int PIPE_DEPTH = 6;

   typedef struct packed {
      logic                      sign;
      logic                      is_zero;
      logic                      is_nar;
      logic [RS_BITS-1:0]        regime_size;
      logic signed [K_BITS-1:0]  regime_value;
      logic [ES_BITS-1:0]        exponent_size;
      logic [EV_BITS-1:0]        exponent_value;
      logic [FS_BITS-1:0]        fraction_size;
      logic [FB_BITS-1:0]        fraction_bits;
   } posit_fields_type;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   pfd_req_if req_if ();
   pfd_rsp_if rsp_if ();

   // shadow of the decoder's registers
   logic [WW_BITS-1:0] word_width_cfg;
   logic [ES_BITS-1:0] exp_width_cfg;

   posit_fields_type expected_fields[$];
   int               error_count;
   bit               sender_idles;
   bit               receiver_stalls;

   posit_field_decoder #(.MAX_WIDTH(64)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Local decoder
   // ------------------------------------------------------------------------
   function automatic logic [63:0] low_bits(input int w);
      if (w >= 64) return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   // word widths outside 2..64 act as the nearest bound
   function automatic int posit_width();
      int n;
      n = int'(word_width_cfg);
      if (n < 2) n = 2;
      if (n > 64) n = 64;
      return n;
   endfunction

   function automatic posit_fields_type decode_posit(input logic [63:0] raw);
      posit_fields_type d;
      int               n, esm, rs, es, fs, pos, k;
      logic [63:0]      mask, top, word, sb, ebits, fbits;
      logic             neg, zero, nar, rsign;
      n     = posit_width();
      esm   = int'(exp_width_cfg);
      mask  = low_bits(n);
      top   = 64'd1 << (n - 1);
      word  = raw & mask;
      neg   = (word & top) != 0;
      zero  = (word == 0);
      nar   = (word == top);
      sb    = neg ? ((((~word) + 64'd1) & mask) | top) : word;
      // measure the regime run below the sign; bit 0 is never part of it
      rsign = sb[n-2];
      rs    = 1;
      for (pos = n - 2; pos >= 1; pos--) begin
         if (sb[pos] != rsign) break;
         rs++;
      end
      es = n - 1 - rs;
      if (es > esm) es = esm;
      fs = n - 1 - rs - es;
      if (zero || nar) begin
         k = -rs;
      end else if (rsign) begin
         // a run of ones that fills the word counts its last bit too
         k = (rs == n - 1 && sb[0]) ? rs - 1 : rs - 2;
      end else begin
         k = 1 - rs;
      end
      fbits = sb & low_bits(fs);
      ebits = ((sb >> fs) & low_bits(es)) << (esm - es);
      d.sign           = neg;
      d.is_zero        = zero;
      d.is_nar         = nar;
      d.regime_size    = rs[RS_BITS-1:0];
      d.regime_value   = k[K_BITS-1:0];
      d.exponent_size  = es[ES_BITS-1:0];
      d.exponent_value = ebits[EV_BITS-1:0];
      d.fraction_size  = fs[FS_BITS-1:0];
      d.fraction_bits  = fbits[FB_BITS-1:0];
      return d;
   endfunction

   // random word shaped around a regime run of random length
   function automatic logic [63:0] shaped_word();
      logic [63:0] w, mask;
      int          n, run, p;
      logic        b;
      n    = posit_width();
      mask = low_bits(n);
      w    = {$urandom, $urandom};
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0: w = w & ~mask;
            1: w = (w & ~mask) | (64'd1 << (n - 1));
            2: w = w | mask;
            default: w = (w & ~mask) | (mask >> 1);
         endcase
      end else begin
         run = $urandom_range(1, n - 1);
         b   = 1'($urandom_range(1));
         for (p = n - 2; p >= n - 1 - run; p--) w[p] = b;
         if (n - 2 - run >= 0) w[n-2-run] = ~b;
      end
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Channel and register traffic
   // ------------------------------------------------------------------------
   // record the expected fields of every accepted request
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         expected_fields.push_back(decode_posit(req_if.posit_word));
   end

   // stall the response side at random
   always @(negedge clock) begin
      if (!reset)
         rsp_if.ready <= !(receiver_stalls && $urandom_range(99) < 16);
   end

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      posit_fields_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_fields.size() == 0) begin
            $display("%0t: response with no request pending, expected none, actual %h",
                     $time, rsp_if.fraction_bits);
            error_count++;
         end else begin
            want = expected_fields.pop_front();
            report_field("sign", 64'(want.sign), 64'(rsp_if.sign));
            report_field("is_zero", 64'(want.is_zero), 64'(rsp_if.is_zero));
            report_field("is_nar", 64'(want.is_nar), 64'(rsp_if.is_nar));
            report_field("regime_size", 64'(want.regime_size), 64'(rsp_if.regime_size));
            report_field("regime_value", 64'(want.regime_value),
                         64'(rsp_if.regime_value));
            report_field("exponent_size", 64'(want.exponent_size),
                         64'(rsp_if.exponent_size));
            report_field("exponent_value", 64'(want.exponent_value),
                         64'(rsp_if.exponent_value));
            report_field("fraction_size", 64'(want.fraction_size),
                         64'(rsp_if.fraction_size));
            report_field("fraction_bits", 64'(want.fraction_bits),
                         64'(rsp_if.fraction_bits));
         end
      end
   end

   // send one request; entered and left at a falling edge
   task automatic send_word(input logic [63:0] raw);
      if (sender_idles && $urandom_range(99) < 8) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.posit_word <= raw;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // hold off until every response is back
   task automatic drain_pipe();
      req_if.valid <= 1'b0;
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] want_rd;
      drain_pipe();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == CSR_WORD_WIDTH) begin
         word_width_cfg = value[WW_BITS-1:0];
         want_rd        = CSR_DATA_BITS'(word_width_cfg);
      end else begin
         exp_width_cfg = (value[ES_BITS-1:0] > ES_LIMIT) ? ES_LIMIT : value[ES_BITS-1:0];
         want_rd       = CSR_DATA_BITS'(exp_width_cfg);
      end
      // read the register back
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (!pready || prdata !== want_rd) begin
         $display("%0t: register %0d read mismatch, expected %h, actual %h",
                  $time, index, want_rd, prdata);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_format(input int ww, input int es);
      write_reg(CSR_WORD_WIDTH, ww);
      write_reg(CSR_EXP_WIDTH, es);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // zero, NaR, extremes of the regime and ignored upper bits at reset format
   task automatic test_reset_defaults();
      logic [63:0] words[15];
      words = '{64'h0, 64'h8000_0000, 64'hFFFF_FFFF, 64'h7FFF_FFFF, 64'h1,
                64'h4000_0000, 64'hC000_0000, 64'h8000_0001, 64'hFFFF_FFFF_0000_0000,
                64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFE, 64'h2, 64'h3FFF_FFFF,
                64'h5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5};
      foreach (words[i]) send_word(words[i]);
   endtask

   // widest and narrowest formats
   task automatic test_width_extremes();
      set_format(64, 16);
      send_word(64'h0);
      send_word(64'h8000_0000_0000_0000);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h7FFF_FFFF_FFFF_FFFF);
      send_word(64'h1);
      set_format(2, 0);
      for (int i = 0; i < 4; i++) send_word(64'hFFFF_FFFF_FFFF_FFFC | 64'(i));
   endtask

   // walk through widths and exponent sizes, out of range values included
   task automatic test_setting_sweep();
      int ww_list[12];
      int es_list[12];
      ww_list = '{0, 1, 2, 3, 5, 8, 16, 32, 63, 64, 65, 127};
      es_list = '{0, 31, 1, 17, 2, 3, 16, 8, 5, 16, 0, 4};
      foreach (ww_list[i]) begin
         set_format(ww_list[i], es_list[i]);
         repeat (100) send_word(shaped_word());
      end
   endtask

   // long stretch with neither side idling
   task automatic test_back_to_back();
      set_format(16, 1);
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      repeat (250) send_word(shaped_word());
      drain_pipe();
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // random formats, pausing now and then until the pipe is empty
   task automatic test_random_settings();
      repeat (5) begin
         set_format($urandom_range(0, 127), $urandom_range(0, 31));
         for (int i = 0; i < 100; i++) begin
            if (i % 40 == 39) drain_pipe();
            send_word(shaped_word());
         end
      end
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_if.valid      = 1'b0;
      req_if.posit_word = '0;
      rsp_if.ready      = 1'b0;
      sender_idles      = 1'b1;
      receiver_stalls   = 1'b1;
      error_count       = 0;
      word_width_cfg    = WW_RESET;
      exp_width_cfg     = ES_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_width_extremes();
      test_setting_sweep();
      test_back_to_back();
      test_random_settings();

      drain_pipe();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (error_count == 0 && expected_fields.size() == 0) begin
         $display("** posit_field_decoder: PASSED **");
      end else begin
         $display("** posit_field_decoder: FAILED **");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #2ms;
      $display("** posit_field_decoder: FAILED **");
      $finish;
   end

endmodule : testbench
